// ----- src/int_to_digit_display_writer_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef INT_TO_DIGIT_DISPLAY_WRITER_CORE_ASSERT_SVH
`define INT_TO_DIGIT_DISPLAY_WRITER_CORE_ASSERT_SVH

// Expression must hold at every clock edge out of reset.
`define ITDW_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("itdw: invariant violated");

// Same-cycle implication.
`define ITDW_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itdw: implication violated");

// Next-cycle implication.
`define ITDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itdw: next-cycle implication violated");

`endif

// ----- src/itdw_pkg.sv -----
// ----------------------------------------------------------------------------
// itdw_pkg
// Types, constants and helper functions of the decimal display writer.
// ----------------------------------------------------------------------------
package itdw_pkg;

  localparam int QUEUE_DEPTH = 2;

  // Number kinds
  localparam logic [1:0] KIND_U8  = 2'd0;
  localparam logic [1:0] KIND_S8  = 2'd1;
  localparam logic [1:0] KIND_U16 = 2'd2;
  localparam logic [1:0] KIND_S16 = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLED     = 2'd0;
  localparam logic [1:0] CFG_BLANK_CODE  = 2'd1;
  localparam logic [1:0] CFG_HYPHEN_CODE = 2'd2;

  localparam logic [7:0] BLANK_CODE_RST  = 8'h0F;
  localparam logic [7:0] HYPHEN_CODE_RST = 8'd10;

  // Reciprocal of ten for 16-bit dividends: q = (x * RECIP) >> 19
  localparam logic [15:0] DIV10_RECIP = 16'hCCCD;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLANK,
    ST_DIGIT
  } state_t;

  // One classified number, handed from the front to the back
  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
    logic [2:0]  len;   // characters to write, hyphen included
    logic [2:0]  del;   // blanked positions right of the number
    logic [3:0]  pos;   // logical position of the rightmost blank or digit
  } desc_t;

  function automatic logic [2:0] kind_max_width(input logic [1:0] kind);
    logic [2:0] w;
    unique case (kind)
      KIND_U8:  w = 3'd3;
      KIND_S8:  w = 3'd4;
      KIND_U16: w = 3'd5;
      KIND_S16: w = 3'd6;
      default:  w = 3'd3;
    endcase
    return w;
  endfunction

  // Number of decimal digits, at least one
  function automatic logic [2:0] mag_digits(input logic [15:0] m);
    logic [2:0] d;
    if (m < 16'd10) begin
      d = 3'd1;
    end else if (m < 16'd100) begin
      d = 3'd2;
    end else if (m < 16'd1000) begin
      d = 3'd3;
    end else if (m < 16'd10000) begin
      d = 3'd4;
    end else begin
      d = 3'd5;
    end
    return d;
  endfunction

  // Logical position to driver digit register
  function automatic logic [3:0] remap_position(input logic [3:0] p);
    logic [3:0] r;
    if (p > 4'd7) begin
      r = 4'd4;
    end else if (p <= 4'd3) begin
      r = p + 4'd5;
    end else begin
      r = p - 4'd3;
    end
    return r;
  endfunction

endpackage

// ----- src/itdw_front.sv -----
// ----------------------------------------------------------------------------
// itdw_front
// Accepts numbers, takes sign and magnitude, sizes the field and queues a
// descriptor for the back end.
// ----------------------------------------------------------------------------
module itdw_front (
  input  logic                enabled,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic signed [16:0]  in_value,
  input  logic [2:0]          in_start_position,
  input  logic [3:0]          in_field_width,
  input  logic                q_full,
  output logic                q_push,
  output itdw_pkg::desc_t     q_desc
);

  logic [15:0] bits;
  logic        sign;
  logic        neg;
  logic [15:0] mag;
  logic [2:0]  max_w;
  logic [2:0]  len_c;
  logic [2:0]  len_k;
  logic [2:0]  digits;
  logic [2:0]  digits_p1;
  logic [2:0]  len_f;

  assign in_stall = q_full;
  // Accept while disabled too, but drop the number.
  assign q_push   = in_valid && !q_full && enabled;

  always_comb begin
    bits  = in_kind[1] ? in_value[15:0] : {8'd0, in_value[7:0]};
    sign  = in_kind[1] ? bits[15] : bits[7];
    neg   = in_kind[0] && sign;
    if (!neg) begin
      mag = bits;
    end else if (in_kind[1]) begin
      mag = ~bits + 16'd1;
    end else begin
      mag = {8'd0, ~bits[7:0] + 8'd1};
    end

    max_w = itdw_pkg::kind_max_width(in_kind);
    if (in_field_width > {1'b0, max_w}) begin
      len_c = max_w;
    end else if (in_field_width == 4'd0) begin
      len_c = 3'd1;
    end else begin
      len_c = in_field_width[2:0];
    end

    // Positive signed16 never uses the sixth position
    if (!neg && in_kind == itdw_pkg::KIND_S16 && len_c == 3'd6) begin
      len_k = 3'd5;
    end else begin
      len_k = len_c;
    end

    digits    = itdw_pkg::mag_digits(mag);
    digits_p1 = digits + 3'd1;
    if (neg) begin
      // Negative fields shrink only while three or more positions remain
      if (len_k < 3'd3) begin
        len_f = len_k;
      end else if (digits_p1 < len_k) begin
        len_f = digits_p1;
      end else begin
        len_f = len_k;
      end
    end else begin
      len_f = (digits < len_k) ? digits : len_k;
    end

    q_desc.neg = neg;
    q_desc.mag = mag;
    q_desc.len = len_f;
    q_desc.del = len_k - len_f;
    q_desc.pos = {1'b0, in_start_position} + {1'b0, len_k} - 4'd1;
  end

endmodule

// ----- src/itdw_queue.sv -----
// ----------------------------------------------------------------------------
// itdw_queue
// Small descriptor FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module itdw_queue #(
  parameter int DEPTH = itdw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  itdw_pkg::desc_t  push_desc,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output itdw_pkg::desc_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  itdw_pkg::desc_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// ----- src/itdw_back.sv -----
// ----------------------------------------------------------------------------
// itdw_back
// Command sequencer: blanks the freed positions, then writes digits, least
// significant first, into an output register, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module itdw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       blank_code,
  input  logic [7:0]       hyphen_code,
  input  logic             q_empty,
  input  itdw_pkg::desc_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_digit_register,
  output logic [7:0]       out_data_code,
  output logic             out_last
);

  itdw_pkg::state_t state_r, state_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] mag_r, mag_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [2:0]  del_r, del_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_reg_r, out_reg_nxt;
  logic [7:0]  out_code_r, out_code_nxt;
  logic        out_last_r, out_last_nxt;

  logic        can_emit;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem_w;

  // Divide by ten through the reciprocal; exact for all 16-bit values
  assign prod  = 32'(mag_r) * 32'(itdw_pkg::DIV10_RECIP);
  assign quot  = {3'd0, prod[31:19]};
  assign rem_w = mag_r - (quot << 3) - (quot << 1);

  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    len_nxt       = len_r;
    del_nxt       = del_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_reg_nxt   = out_reg_r;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    unique case (state_r)
      itdw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          neg_nxt   = q_head.neg;
          mag_nxt   = q_head.mag;
          len_nxt   = q_head.len;
          del_nxt   = q_head.del;
          pos_nxt   = q_head.pos;
          state_nxt = (q_head.del != 3'd0) ? itdw_pkg::ST_BLANK : itdw_pkg::ST_DIGIT;
        end
      end
      itdw_pkg::ST_BLANK: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_reg_nxt   = itdw_pkg::remap_position(pos_r);
          out_code_nxt  = blank_code;
          out_last_nxt  = 1'b0;
          pos_nxt       = pos_r - 4'd1;
          del_nxt       = del_r - 3'd1;
          if (del_r == 3'd1) begin
            state_nxt = itdw_pkg::ST_DIGIT;
          end
        end
      end
      itdw_pkg::ST_DIGIT: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_reg_nxt   = itdw_pkg::remap_position(pos_r);
          // Hyphen takes the leftmost place of a negative number
          out_code_nxt  = (neg_r && len_r == 3'd1) ? hyphen_code : {4'd0, rem_w[3:0]};
          out_last_nxt  = (len_r == 3'd1);
          mag_nxt       = quot;
          pos_nxt       = (pos_r != 4'd0) ? pos_r - 4'd1 : 4'd0;
          len_nxt       = len_r - 3'd1;
          if (len_r == 3'd1) begin
            state_nxt = itdw_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = itdw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itdw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    len_r      <= len_nxt;
    del_r      <= del_nxt;
    pos_r      <= pos_nxt;
    out_reg_r  <= out_reg_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_digit_register = out_reg_r;
  assign out_data_code      = out_code_r;
  assign out_last           = out_last_r;

endmodule

// ----- src/int_to_digit_display_writer_core.sv -----
// A number passes the descriptor queue and the sequencer's load state before
//   its first command word is registered; then one command word per cycle
//   while out_stall is low, one for each blank and each character.
// A descriptor queue of QUEUE_DEPTH entries lets the front keep accepting until it fills.
// Reset (rst_n low, synchronous): queue and sequencer empty, output invalid,
//   enabled = 0, blank_code = 15, hyphen_code = 10.
// ----------------------------------------------------------------------------
// int_to_digit_display_writer_core
// Formats integers as decimal command words for a code-B digit display driver.
// ----------------------------------------------------------------------------
module int_to_digit_display_writer_core #(
  parameter int QUEUE_DEPTH = itdw_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [16:0] in_value,
  input  logic [2:0]         in_start_position,
  input  logic [3:0]         in_field_width,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_digit_register,
  output logic [7:0]         out_data_code,
  output logic               out_last
);

  logic            enabled_r;
  logic [7:0]      blank_code_r;
  logic [7:0]      hyphen_code_r;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  itdw_pkg::desc_t q_desc;
  itdw_pkg::desc_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= 1'b0;
      blank_code_r  <= itdw_pkg::BLANK_CODE_RST;
      hyphen_code_r <= itdw_pkg::HYPHEN_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        itdw_pkg::CFG_ENABLED:     enabled_r     <= cfg_data[0];
        itdw_pkg::CFG_BLANK_CODE:  blank_code_r  <= cfg_data;
        itdw_pkg::CFG_HYPHEN_CODE: hyphen_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  itdw_front u_front (
    .enabled           (enabled_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_start_position (in_start_position),
    .in_field_width    (in_field_width),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_desc            (q_desc)
  );

  itdw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  itdw_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .blank_code         (blank_code_r),
    .hyphen_code        (hyphen_code_r),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_register (out_digit_register),
    .out_data_code      (out_data_code),
    .out_last           (out_last)
  );

endmodule

// ----- src/itdw_checker.sv -----
// ----------------------------------------------------------------------------
// itdw_checker
// Port-level checks of the decimal display writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "int_to_digit_display_writer_core_assert.svh"

module itdw_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         out_digit_register,
  input logic [7:0]         out_data_code,
  input logic               out_last
);

  logic [12:0] out_word;
  logic        reg_ok;

  assign out_word = {out_digit_register, out_data_code, out_last};
  assign reg_ok   = (out_digit_register != 4'd0) && (out_digit_register <= 4'd8);

  // Stalled beat holds
  `ITDW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // Remap only reaches driver registers one to eight
  `ITDW_ASSERT_ALWAYS(a_reg_range, !out_valid || reg_ok)

  // Commands of one number come without gaps
  `ITDW_ASSERT_NEXT(a_burst, out_valid && !out_stall && !out_last, out_valid)

  // Output is empty right after reset
  `ITDW_ASSERT_IMPLY(a_reset_clear, $past(rst_n) == 1'b0, !out_valid)

endmodule

bind int_to_digit_display_writer_core itdw_checker u_itdw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_digit_register (out_digit_register),
  .out_data_code      (out_data_code),
  .out_last           (out_last)
);

// ----- tb/tb_int_to_digit_display_writer_core.sv -----
// ----------------------------------------------------------------------------
// tb_int_to_digit_display_writer_core
// Self-checking bench for the decimal display writer. Numbers go in as
// valid/stall beats; a local formatter predicts the command words each one
// should produce, and every output beat is checked against the oldest
// pending word. Runs a reset-state phase with the block off, directed corner
// cases, a disabled phase and a long output hold-off, then random numbers under
// several blank/hyphen code settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_int_to_digit_display_writer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_SETTLE  = 24;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_BATCH = 45;

  typedef struct {
    logic [3:0] digit_register;
    logic [7:0] data_code;
    logic       last;
  } command_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = '0;
  logic signed [16:0] in_value = '0;
  logic [2:0]         in_start_position = '0;
  logic [3:0]         in_field_width = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_digit_register;
  logic [7:0]         out_data_code;
  logic               out_last;

  // Local copy of the register file
  logic       cfg_on = 1'b0;
  logic [7:0] cfg_blank = itdw_pkg::BLANK_CODE_RST;
  logic [7:0] cfg_hyphen = itdw_pkg::HYPHEN_CODE_RST;

  command_t expected_cmds[$];
  int       errors = 0;
  int       numbers_sent = 0;
  int       words_checked = 0;
  int       code_settings = 0;
  int       quiet_cycles = 0;
  bit       send_gaps = 1'b0;
  bit       recv_gaps = 1'b0;
  int       hold_left = 0;
  int       stall_left = 0;

  int_to_digit_display_writer_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_value           (in_value),
    .in_start_position  (in_start_position),
    .in_field_width     (in_field_width),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_register (out_digit_register),
    .out_data_code      (out_data_code),
    .out_last           (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [3:0] register_of(input int unsigned p);
    if (p > 7) return 4'd4;
    if (p <= 3) return 4'(p + 5);
    return 4'(p - 3);
  endfunction

  // Format one number into driver command words and queue them
  task automatic predict_commands(input logic [1:0] kind, input logic [16:0] value,
                                  input logic [2:0] start, input logic [3:0] width);
    int unsigned tens [5];
    int unsigned mask, bits, mag, len, top, del, pos, i;
    bit          neg;
    command_t    cmd;
    tens = '{1, 10, 100, 1000, 10000};
    if (!cfg_on) return;
    mask = kind[1] ? 32'hFFFF : 32'hFF;
    bits = 32'(value) & mask;
    neg  = kind[0] && ((bits & ((mask >> 1) + 1)) != 0);
    mag  = neg ? ((~bits + 1) & mask) : bits;
    case (kind)
      itdw_pkg::KIND_U8:  top = 3;
      itdw_pkg::KIND_S8:  top = 4;
      itdw_pkg::KIND_U16: top = 5;
      default:            top = 6;
    endcase
    len = 32'(width);
    if (len > top) len = top;
    else if (len < 1) len = 1;
    del = 0;
    // Shrink the field over leading zeros; the hyphen keeps one place
    if (neg) begin
      while (len >= 3 && mag < tens[len - 2]) begin
        len--;
        del++;
      end
    end else begin
      if (kind == itdw_pkg::KIND_S16 && len == 6) len = 5;
      while (len >= 2 && mag < tens[len - 1]) begin
        len--;
        del++;
      end
    end
    pos = 32'(start) + len - 1 + del;
    while (del > 0) begin
      cmd.digit_register = register_of(pos);
      cmd.data_code      = cfg_blank;
      cmd.last           = 1'b0;
      expected_cmds.push_back(cmd);
      pos--;
      del--;
    end
    for (i = 0; i < len; i++) begin
      cmd.digit_register = register_of(pos);
      if (neg && i == len - 1) begin
        cmd.data_code = cfg_hyphen;
      end else begin
        cmd.data_code = 8'(mag % 10);
        mag = mag / 10;
      end
      cmd.last = (i == len - 1);
      expected_cmds.push_back(cmd);
      if (pos > 0) pos--;
    end
  endtask

  task automatic send_number(input logic [1:0] kind, input int value,
                             input logic [2:0] start, input logic [3:0] width);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_kind           = kind;
    in_value          = value[16:0];
    in_start_position = start;
    in_field_width    = width;
    do @(posedge clk); while (in_stall);
    predict_commands(kind, value[16:0], start, width);
    numbers_sent++;
  endtask

  task automatic send_random_number();
    logic [1:0] kind;
    int         value, mag, decade, lo, hi, p;
    kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 6) == 0) begin
      // anywhere from -32768 to 65535, kind limits ignored
      value = int'($urandom_range(0, 98303)) - 32768;
    end else begin
      // pick the digit count first so short numbers are common
      decade = $urandom_range(0, kind[1] ? 4 : 2);
      p = 1;
      repeat (decade) p = p * 10;
      lo = (decade == 0) ? 0 : p;
      hi = p * 10 - 1;
      if (hi > (kind[1] ? 65535 : 255)) hi = kind[1] ? 65535 : 255;
      mag = int'($urandom_range(lo, hi));
      if (kind[0] && $urandom_range(0, 1) == 1) value = (mag > 32768) ? -32768 : -mag;
      else value = mag;
    end
    send_number(kind, value, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
  endtask

  // Drop valid, drain every pending word, then let in-flight work settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      itdw_pkg::CFG_ENABLED:     cfg_on = data[0];
      itdw_pkg::CFG_BLANK_CODE:  cfg_blank = data;
      itdw_pkg::CFG_HYPHEN_CODE: cfg_hyphen = data;
      default: ;
    endcase
  endtask

  task automatic set_codes(input logic [7:0] blank, input logic [7:0] hyphen);
    write_reg(itdw_pkg::CFG_BLANK_CODE, blank);
    write_reg(itdw_pkg::CFG_HYPHEN_CODE, hyphen);
    code_settings++;
  endtask

  // Out of reset the block is off; numbers must vanish
  task automatic test_reset_state();
    repeat (3) send_random_number();
    wait_idle();
    write_reg(itdw_pkg::CFG_ENABLED, 8'd1);
    code_settings++;
  endtask

  // Corner cases with the reset blank and hyphen codes
  task automatic test_directed_cases();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_number(itdw_pkg::KIND_U8,       0, 3'd0, 4'd0);
    send_number(itdw_pkg::KIND_U8,     255, 3'd7, 4'd15);
    send_number(itdw_pkg::KIND_U8,       7, 3'd3, 4'd3);
    send_number(itdw_pkg::KIND_U8,     300, 3'd2, 4'd3);
    send_number(itdw_pkg::KIND_U8,      -1, 3'd0, 4'd3);
    send_number(itdw_pkg::KIND_S8,    -128, 3'd0, 4'd4);
    send_number(itdw_pkg::KIND_S8,      -5, 3'd2, 4'd4);
    send_number(itdw_pkg::KIND_S8,    -100, 3'd0, 4'd2);
    send_number(itdw_pkg::KIND_S8,      -9, 3'd5, 4'd1);
    send_number(itdw_pkg::KIND_S8,     127, 3'd0, 4'd4);
    send_number(itdw_pkg::KIND_S8,     200, 3'd1, 4'd4);
    send_number(itdw_pkg::KIND_U16,  65535, 3'd0, 4'd5);
    send_number(itdw_pkg::KIND_U16,  12345, 3'd4, 4'd3);
    send_number(itdw_pkg::KIND_U16,      0, 3'd3, 4'd5);
    send_number(itdw_pkg::KIND_U16, -32768, 3'd0, 4'd5);
    send_number(itdw_pkg::KIND_S16, -32768, 3'd0, 4'd6);
    send_number(itdw_pkg::KIND_S16,  32767, 3'd2, 4'd6);
    send_number(itdw_pkg::KIND_S16,      5, 3'd0, 4'd6);
    send_number(itdw_pkg::KIND_S16,     -1, 3'd7, 4'd15);
    send_number(itdw_pkg::KIND_S16,  65535, 3'd0, 4'd6);
    send_number(itdw_pkg::KIND_S16, -12345, 3'd1, 4'd6);
    wait_idle();
  endtask

  task automatic test_disabled();
    write_reg(itdw_pkg::CFG_ENABLED, 8'd0);
    repeat (4) send_random_number();
    wait_idle();
    write_reg(itdw_pkg::CFG_ENABLED, 8'd1);
  endtask

  // Hold the output off while numbers keep coming, so the input backs up
  task automatic test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (10) send_random_number();
    wait_idle();
  endtask

  task automatic test_random_phase(input logic [7:0] blank, input logic [7:0] hyphen,
                                   input bit sgaps, input bit rgaps, input bit pause);
    set_codes(blank, hyphen);
    send_gaps = sgaps;
    recv_gaps = rgaps;
    for (int i = 0; i < RANDOM_BATCH; i++) begin
      send_random_number();
      // stop sending until every word so far is out
      if (pause && i == RANDOM_BATCH / 2) begin
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
      end
    end
    wait_idle();
  endtask

  // Output side: random stall after each beat when recv_gaps is set, plus the long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && recv_gaps) stall_left = $urandom_range(0, 3);
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    command_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cmds.size() == 0) begin
        report_error($sformatf("unexpected beat: register %0d code %0d last %0b",
                               out_digit_register, out_data_code, out_last));
      end else begin
        want = expected_cmds.pop_front();
        if (out_digit_register !== want.digit_register)
          report_error($sformatf("digit register: got %0d, want %0d",
                                 out_digit_register, want.digit_register));
        if (out_data_code !== want.data_code)
          report_error($sformatf("data code: got %0d, want %0d",
                                 out_data_code, want.data_code));
        if (out_last !== want.last)
          report_error($sformatf("last flag: got %0b, want %0b", out_last, want.last));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat in %0d cycles, %0d words pending",
               QUIET_LIMIT, expected_cmds.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_directed_cases();
    test_disabled();
    test_backpressure();
    test_random_phase(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
    test_random_phase(8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
    test_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b1, 1'b0, 1'b1);
    test_random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'b0, 1'b1, 1'b1);
    $display("Summary: %0d numbers in, %0d command words checked, %0d code settings,",
             numbers_sent, words_checked, code_settings);
    $display("  incl. disabled phases, output hold-off and drain pauses; %0d errors",
             errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
